// ===== hdl/dfcc_pkg.sv =====
package dfcc_pkg;

   localparam int ADDRESS_CHARS = 6;
   localparam int ADDR_W        = 8 * ADDRESS_CHARS;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [7:0] CHAR_BAR = 8'h7C;
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   // field numbers along a line
   localparam logic [2:0] FIELD_FROM = 3'd0;
   localparam logic [2:0] FIELD_TO   = 3'd1;
   localparam logic [2:0] FIELD_TYPE = 3'd2;
   localparam logic [2:0] FIELD_DATA = 3'd3;
   localparam logic [2:0] FIELD_CRC  = 3'd4;
   localparam logic [2:0] FIELD_PAST = 3'd5;

   localparam logic [3:0] FIELD_LEN_MAX = 4'd15;
   localparam logic [3:0] CRC_TEXT_LEN  = 4'd8;
   localparam logic [3:0] BCAST_LEN     = 4'd9;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FORMAT = 2'd1;
   localparam logic [1:0] STATUS_CRC    = 2'd2;

   localparam logic [1:0] DEST_OTHER = 2'd0;
   localparam logic [1:0] DEST_OWN   = 2'd1;
   localparam logic [1:0] DEST_BCAST = 2'd2;

   localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

   localparam int TYPE_COUNT  = 6;
   localparam int TYPE_TEXT_W = 8 * 13;

   localparam logic [71:0] BCAST_TEXT = 72'("BROADCAST");

   localparam logic [TYPE_TEXT_W-1:0] TYPE_TEXT [TYPE_COUNT] = '{
      TYPE_TEXT_W'("HEARTBEAT"),
      TYPE_TEXT_W'("ACTION"),
      TYPE_TEXT_W'({"GET_", "REGISTER"}),
      TYPE_TEXT_W'({"GET_", "REGISTERS"}),
      TYPE_TEXT_W'({"SET_", "REGISTER"}),
      TYPE_TEXT_W'("PING")
   };

   localparam logic [3:0] TYPE_LEN [TYPE_COUNT] = '{
      4'd9, 4'd6, 4'd12, 4'd13, 4'd12, 4'd4
   };

   // one byte of the reflected CRC-32, bit by bit
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   // character at a position of a type name; positions past its end give zero
   function automatic logic [7:0] type_char(input int k, input logic [3:0] pos);
      logic [TYPE_TEXT_W-1:0] word;
      int sh;
      word = TYPE_TEXT[k];
      sh   = 8 * (int'(TYPE_LEN[k]) - 1 - int'(pos));
      if (sh < 0) begin
         return 8'h00;
      end
      return word[sh +: 8];
   endfunction

   function automatic logic [7:0] bcast_char(input logic [3:0] pos);
      int sh;
      sh = 8 * (int'(BCAST_LEN) - 1 - int'(pos));
      if (sh < 0) begin
         return 8'h00;
      end
      return BCAST_TEXT[sh +: 8];
   endfunction

   function automatic logic [7:0] own_char(input logic [ADDR_W-1:0] addr,
                                           input logic [3:0] pos);
      int sh;
      sh = 8 * (ADDRESS_CHARS - 1 - int'(pos));
      if (sh < 0) begin
         return 8'h00;
      end
      return addr[sh +: 8];
   endfunction

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] kind;
      logic [2:0] code;
   } result_type;

endpackage

// ===== hdl/delimited_frame_crc_checker_top.sv =====
// The result of a line is registered in the result queue when its newline is taken.
// Throughput: one received byte per cycle while req_tready is high; the CRC byte update
//    and the field compares are combinational.
// A two-entry result queue (output register plus skid register) lets bytes flow while
//    a result waits; req_tready falls only while both entries are occupied.
// Reset (synchronous, active high) clears own_address to zero and returns the line
//    state to its start: CRC all ones, no fields seen, all match flags set.
module delimited_frame_crc_checker_top import dfcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,    // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,    // [1:0] frame_status, [3:2] destination_kind,
                                           // [6:4] type_code, [7] zero
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data   // own_address, first character in top byte
);

   // configuration
   logic [ADDR_W-1:0] own_address_ff;

   // line state
   logic [31:0]           crc_ff,          crc_in;
   logic [2:0]            field_index_ff,  field_index_in;
   logic [3:0]            field_len_ff,    field_len_in;
   logic [4:0]            nonempty_ff,     nonempty_in;
   logic                  started_ff,      started_in;
   logic [1:0]            dest_flags_ff,   dest_flags_in;
   logic [TYPE_COUNT-1:0] type_flags_ff,   type_flags_in;
   logic [31:0]           rx_crc_ff,       rx_crc_in;
   logic                  crc_text_ok_ff,  crc_text_ok_in;

   // result queue
   logic       out_valid_ff,  out_valid_in;
   result_type out_ff,        out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff,       skid_in;

   logic       accept;
   logic       take;
   logic       produce;
   result_type result;

   // values of the match flags once the current field is closed
   logic [1:0]            close_dest;
   logic [TYPE_COUNT-1:0] close_type;
   logic                  close_crc_ok;

   logic [7:0] b;
   logic [3:0] nib;
   logic       is_hex;

   assign b          = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.code, out_ff.kind, out_ff.status};

   // close the open field: a length that differs from a candidate drops that candidate
   always_comb begin
      close_dest   = dest_flags_ff;
      close_type   = type_flags_ff;
      close_crc_ok = crc_text_ok_ff;
      case (field_index_ff)
         FIELD_TO: begin
            if (field_len_ff != 4'(ADDRESS_CHARS)) close_dest[0] = 1'b0;
            if (field_len_ff != BCAST_LEN)         close_dest[1] = 1'b0;
         end
         FIELD_TYPE: begin
            for (int k = 0; k < TYPE_COUNT; k++) begin
               if (field_len_ff != TYPE_LEN[k]) close_type[k] = 1'b0;
            end
         end
         FIELD_CRC: begin
            if (field_len_ff != CRC_TEXT_LEN) close_crc_ok = 1'b0;
         end
         default: ;
      endcase
   end

   // hex digit of the crc field: uppercase only
   always_comb begin
      is_hex = 1'b1;
      nib    = 4'd0;
      if (b inside {["0":"9"]}) begin
         nib = 4'(b - 8'h30);
      end else if (b inside {["A":"F"]}) begin
         nib = 4'(b - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   // report of a finished line
   always_comb begin
      result.status = STATUS_OK;
      result.kind   = DEST_OTHER;
      result.code   = TYPE_UNKNOWN;
      if (nonempty_ff != 5'h1F) begin
         result.status = STATUS_FORMAT;
      end else if (!close_crc_ok || rx_crc_ff != ~crc_ff) begin
         result.status = STATUS_CRC;
      end else begin
         // own address wins over broadcast
         if (close_dest[0]) begin
            result.kind = DEST_OWN;
         end else if (close_dest[1]) begin
            result.kind = DEST_BCAST;
         end
         // lowest set flag gives the type
         for (int k = TYPE_COUNT - 1; k >= 0; k--) begin
            if (close_type[k]) result.code = 3'(k + 1);
         end
      end
   end

   // line state update for one received byte
   always_comb begin
      crc_in         = crc_ff;
      field_index_in = field_index_ff;
      field_len_in   = field_len_ff;
      nonempty_in    = nonempty_ff;
      started_in     = started_ff;
      dest_flags_in  = dest_flags_ff;
      type_flags_in  = type_flags_ff;
      rx_crc_in      = rx_crc_ff;
      crc_text_ok_in = crc_text_ok_ff;
      produce        = 1'b0;

      if (accept && b != CHAR_CR) begin
         if (b == CHAR_NL) begin
            // report only a line that held something, then start afresh
            produce        = started_ff;
            crc_in         = CRC_INIT;
            field_index_in = FIELD_FROM;
            field_len_in   = 4'd0;
            nonempty_in    = 5'd0;
            started_in     = 1'b0;
            dest_flags_in  = '1;
            type_flags_in  = '1;
            rx_crc_in      = 32'd0;
            crc_text_ok_in = 1'b1;
         end else if (b == CHAR_BAR) begin
            started_in = 1'b1;
            // the fourth bar is the first one outside the checksum
            if (field_index_ff < FIELD_DATA) crc_in = crc32_byte(crc_ff, b);
            dest_flags_in  = close_dest;
            type_flags_in  = close_type;
            crc_text_ok_in = close_crc_ok;
            if (field_index_ff < FIELD_PAST) field_index_in = field_index_ff + 3'd1;
            field_len_in = 4'd0;
         end else begin
            started_in = 1'b1;
            if (field_index_ff <= FIELD_DATA) crc_in = crc32_byte(crc_ff, b);
            if (field_index_ff < FIELD_PAST) begin
               nonempty_in[field_index_ff] = 1'b1;
               case (field_index_ff)
                  FIELD_TO: begin
                     if (field_len_ff >= 4'(ADDRESS_CHARS) ||
                         b != own_char(own_address_ff, field_len_ff))
                        dest_flags_in[0] = 1'b0;
                     if (field_len_ff >= BCAST_LEN || b != bcast_char(field_len_ff))
                        dest_flags_in[1] = 1'b0;
                  end
                  FIELD_TYPE: begin
                     for (int k = 0; k < TYPE_COUNT; k++) begin
                        if (field_len_ff >= TYPE_LEN[k] || b != type_char(k, field_len_ff))
                           type_flags_in[k] = 1'b0;
                     end
                  end
                  FIELD_CRC: begin
                     if (field_len_ff >= CRC_TEXT_LEN || !is_hex) begin
                        crc_text_ok_in = 1'b0;
                     end else begin
                        rx_crc_in = {rx_crc_ff[27:0], nib};
                     end
                  end
                  default: ;
               endcase
               if (field_len_ff < FIELD_LEN_MAX) field_len_in = field_len_ff + 4'd1;
            end
         end
      end
   end

   // result queue: refill the output register from the skid entry first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = produce;
         out_in       = result;
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         crc_ff         <= CRC_INIT;
         field_index_ff <= FIELD_FROM;
         field_len_ff   <= 4'd0;
         nonempty_ff    <= 5'd0;
         started_ff     <= 1'b0;
         dest_flags_ff  <= '1;
         type_flags_ff  <= '1;
         rx_crc_ff      <= 32'd0;
         crc_text_ok_ff <= 1'b1;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) own_address_ff <= csr_wr_data;
         crc_ff         <= crc_in;
         field_index_ff <= field_index_in;
         field_len_ff   <= field_len_in;
         nonempty_ff    <= nonempty_in;
         started_ff     <= started_in;
         dest_flags_ff  <= dest_flags_in;
         type_flags_ff  <= type_flags_in;
         rx_crc_ff      <= rx_crc_in;
         crc_text_ok_ff <= crc_text_ok_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // payload: hold without reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
